### rtl/d2r_pkg.sv
// Package for the decimal to Roman numeral encoder.
// Holds the symbol table, the controller state type and the control and status structs.
// No dependencies.
`timescale 1ns / 1ps

package d2r_pkg;

  localparam int VALUE_W = 12;
  localparam int LETTER_W = 8;
  localparam int SYM_COUNT = 13;
  localparam int SYM_IDX_W = $clog2(SYM_COUNT);
  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  localparam logic [LETTER_W-1:0] CH_NONE = 8'h00;
  localparam logic [LETTER_W-1:0] CH_M = 8'h4D;
  localparam logic [LETTER_W-1:0] CH_D = 8'h44;
  localparam logic [LETTER_W-1:0] CH_C = 8'h43;
  localparam logic [LETTER_W-1:0] CH_L = 8'h4C;
  localparam logic [LETTER_W-1:0] CH_X = 8'h58;
  localparam logic [LETTER_W-1:0] CH_V = 8'h56;
  localparam logic [LETTER_W-1:0] CH_I = 8'h49;

  localparam logic [VALUE_W-1:0] SYM_WEIGHT [SYM_COUNT] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };

  localparam logic [LETTER_W-1:0] SYM_FIRST [SYM_COUNT] = '{
    CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
  };

  localparam logic [LETTER_W-1:0] SYM_SECOND [SYM_COUNT] = '{
    CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L, CH_NONE,
    CH_X, CH_NONE, CH_V, CH_NONE
  };

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } d2r_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } d2r_cmd_t;

  typedef struct packed {
    logic last;
  } d2r_stat_t;

  // Index of the largest symbol whose weight does not exceed the remainder.
  function automatic logic [SYM_IDX_W-1:0] sym_select(input logic [VALUE_W-1:0] rest);
    logic [SYM_IDX_W-1:0] idx;
    idx = SYM_IDX_W'(SYM_COUNT - 1);
    for (int k = SYM_COUNT - 1; k >= 0; k--) begin
      if (rest >= SYM_WEIGHT[k]) begin
        idx = SYM_IDX_W'(k);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/decimal_to_roman_encoder_top.sv
// Top level of the decimal to Roman numeral encoder.
// Instantiates d2r_ctrl and d2r_dp; depends on d2r_pkg.
//
//   Channel   Ports                          Transfer
//   request   start, busy, value             start high while busy low
//   result    strobe, letter, last, error    strobe high, one cycle each
//
// A request is loaded when it is taken, and the first letter follows in the next
// cycle, then one letter per cycle without gaps (1 to 15 letters); an invalid value
// gives a single error result.
// Synchronous reset returns the controller to idle; the receiver cannot stall.
`timescale 1ns / 1ps

module decimal_to_roman_encoder_top import d2r_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [VALUE_W-1:0]  value,
  output logic                strobe,
  output logic [LETTER_W-1:0] letter,
  output logic                last,
  output logic                error
);

  d2r_cmd_t  cmd;
  d2r_stat_t stat;

  d2r_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  d2r_dp u_dp (
    .clk    (clk),
    .value  (value),
    .cmd    (cmd),
    .stat   (stat),
    .letter (letter),
    .last   (last),
    .error  (error)
  );

endmodule

### rtl/d2r_ctrl.sv
// Controller state machine of the decimal to Roman numeral encoder.
// Depends on d2r_pkg; drives the datapath commands and the handshake outputs.
`timescale 1ns / 1ps

module d2r_ctrl import d2r_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  d2r_stat_t stat,
  output d2r_cmd_t  cmd,
  output logic      busy,
  output logic      strobe
);

  d2r_state_t state;
  d2r_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    busy = 1'b0;
    strobe = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        busy = 1'b1;
        strobe = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

### rtl/d2r_dp.sv
// Datapath of the decimal to Roman numeral encoder: remainder, pair phase and error flag.
// Depends on d2r_pkg for the symbol table and the command and status structs.
`timescale 1ns / 1ps

module d2r_dp import d2r_pkg::*; (
  input  logic                clk,
  input  logic [VALUE_W-1:0]  value,
  input  d2r_cmd_t            cmd,
  output d2r_stat_t           stat,
  output logic [LETTER_W-1:0] letter,
  output logic                last,
  output logic                error
);

  logic [VALUE_W-1:0]   rest;
  logic                 phase;
  logic                 err;
  logic [SYM_IDX_W-1:0] sel;
  logic                 is_pair;
  logic                 sym_done;
  logic [VALUE_W-1:0]   rest_next;

  assign sel = sym_select(rest);
  assign is_pair = (SYM_SECOND[sel] != CH_NONE);
  assign sym_done = phase || !is_pair;
  assign rest_next = rest - SYM_WEIGHT[sel];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest <= value;
      phase <= 1'b0;
      err <= (value == '0) || (value > VALUE_MAX);
    end else if (cmd.step && !err) begin
      if (sym_done) begin
        rest <= rest_next;
        phase <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  assign letter = err ? CH_NONE : (phase ? SYM_SECOND[sel] : SYM_FIRST[sel]);
  assign last = err || (sym_done && (rest_next == '0));
  assign error = err;
  assign stat.last = last;

endmodule

### rtl/d2r_checker.sv
// Port-level checker for the decimal to Roman numeral encoder, bound to the top level.
// Depends on d2r_pkg for widths and the letter code of an error result.
`timescale 1ns / 1ps

module d2r_checker import d2r_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                strobe,
  input logic [LETTER_W-1:0] letter,
  input logic                last,
  input logic                error
);

  // A request that is taken starts output in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && strobe)
    else $error("request accepted but no output followed");

  // Letters come back to back while busy.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    busy |-> strobe)
    else $error("gap in the letter run");

  // The final letter frees the block.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy)
    else $error("block still busy after the final letter");

  // An error result is a single result with no letter.
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    strobe && error |-> last && (letter == CH_NONE))
    else $error("malformed error result");

  // A valid letter is never the null code.
  a_letter_code: assert property (@(posedge clk) disable iff (rst)
    strobe && !error |-> (letter != CH_NONE))
    else $error("null letter in a valid numeral");

endmodule

bind decimal_to_roman_encoder_top d2r_checker u_d2r_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .letter (letter),
  .last   (last),
  .error  (error)
);

### dv/decimal_to_roman_encoder_top_tb.sv
// Self-checking testbench for decimal_to_roman_encoder_top.
// A scoreboard class builds each numeral and checks every letter that the block emits.
// Depends on d2r_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module decimal_to_roman_encoder_top_tb;
  import d2r_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_REQUESTS = 250;

  localparam int ROMAN_WEIGHT [13] = '{
    1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
  };
  localparam logic [LETTER_W-1:0] ROMAN_FIRST [13] = '{
    CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
  };
  localparam logic [LETTER_W-1:0] ROMAN_SECOND [13] = '{
    CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L, CH_NONE,
    CH_X, CH_NONE, CH_V, CH_NONE
  };

  typedef struct {
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                error;
  } roman_char_t;

  class numeral_scoreboard;
    roman_char_t pending_chars[$];
    int          failures;

    function new();
      failures = 0;
    endfunction

    function void note_request(logic [VALUE_W-1:0] v);
      roman_char_t numeral[$];
      roman_char_t c;
      int          rest;
      rest = int'(v);
      c.last = 1'b0;
      c.error = 1'b0;
      if (rest == 0 || rest > int'(VALUE_MAX)) begin
        c.letter = CH_NONE;
        c.last = 1'b1;
        c.error = 1'b1;
        pending_chars.push_back(c);
        return;
      end
      for (int k = 0; k < 13; k++) begin
        while (rest >= ROMAN_WEIGHT[k]) begin
          c.letter = ROMAN_FIRST[k];
          numeral.push_back(c);
          if (ROMAN_SECOND[k] != CH_NONE) begin
            c.letter = ROMAN_SECOND[k];
            numeral.push_back(c);
          end
          rest -= ROMAN_WEIGHT[k];
        end
      end
      numeral[numeral.size() - 1].last = 1'b1;
      foreach (numeral[i]) pending_chars.push_back(numeral[i]);
    endfunction

    function void check_result(logic [LETTER_W-1:0] l, logic lst, logic err);
      roman_char_t exp_c;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected result letter %h last %b error %b", $time, l, lst, err);
        failures++;
        return;
      end
      exp_c = pending_chars.pop_front();
      if (l !== exp_c.letter) begin
        $display("%0t: letter expected %h actual %h", $time, exp_c.letter, l);
        failures++;
      end
      if (lst !== exp_c.last) begin
        $display("%0t: last expected %b actual %b", $time, exp_c.last, lst);
        failures++;
      end
      if (err !== exp_c.error) begin
        $display("%0t: error expected %b actual %b", $time, exp_c.error, err);
        failures++;
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [VALUE_W-1:0]  value;
  logic                strobe;
  logic [LETTER_W-1:0] letter;
  logic                last;
  logic                error;

  numeral_scoreboard numerals = new();
  int                quiet_cycles = 0;
  bit                burst_mode = 1'b0;

  decimal_to_roman_encoder_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .value  (value),
    .strobe (strobe),
    .letter (letter),
    .last   (last),
    .error  (error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      numerals.check_result(letter, last, error);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_value(logic [VALUE_W-1:0] v);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do begin
      @(posedge clk);
    end while (busy);
    numerals.note_request(v);
  endtask

  task automatic send_random_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_value(VALUE_W'($urandom_range(0, 4095)));
    end else if (pick < 8) begin
      send_value('0);
    end else if (pick < 12) begin
      send_value(VALUE_W'($urandom_range(4000, 4095)));
    end else if (pick < 22) begin
      send_value(VALUE_W'($urandom_range(1, 50)));
    end else begin
      send_value(VALUE_W'($urandom_range(1, 3999)));
    end
  endtask

  initial begin
    logic [VALUE_W-1:0] directed[$];
    rst <= 1'b1;
    start <= 1'b0;
    value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    directed = '{12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888, 12'd4,
                 12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50,
                 12'd500, 12'd1000, 12'd3, 12'd14, 12'd444, 12'd999,
                 12'd1994, 12'd2048, 12'd3000};
    foreach (directed[i]) send_value(directed[i]);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 20 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      send_random_value();
    end
    start <= 1'b0;

    while (numerals.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (numerals.failures == 0 && numerals.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/d2r_pkg.sv
rtl/d2r_ctrl.sv
rtl/d2r_dp.sv
rtl/decimal_to_roman_encoder_top.sv
rtl/d2r_checker.sv
dv/decimal_to_roman_encoder_top_tb.sv
